[src/wsts_pkg.sv]
// Shared types and constants for the weighted sum tree sampler.
// No dependencies; used by wsts_ctrl, wsts_dp and weighted_sum_tree_sampler.
`default_nettype none

package wsts_pkg;

    localparam int IDX_W     = 10;
    localparam int W_W       = 32;
    localparam int SUM_W     = 42;
    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 96;

    localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW_SRC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW_TGT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_OWN_READ,
        OP_DELTA,
        OP_CLIMB,
        OP_MULT,
        OP_SCALE,
        OP_DRAW_READ,
        OP_DRAW_EVAL,
        OP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_draw;
        logic write_bad;
        logic draw_empty;
        logic pick_done;
        logic at_root;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/wsts_ctrl.sv]
// Controller state machine of the weighted sum tree sampler.
// Depends on wsts_pkg; drives the datapath wsts_dp through command and status structs.
`default_nettype none

module wsts_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire wsts_pkg::dp_stat_t   stat,
    output wsts_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OWN_RD,
        S_DELTA,
        S_CLIMB,
        S_MULT,
        S_SCALE,
        S_DRAW_RD,
        S_DRAW_EVAL,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic                s_tready_reg;
    logic                m_tvalid_reg;
    wsts_pkg::status_t   status_reg;
    logic                accept;
    logic                out_free;

    assign accept   = s_tvalid && s_tready_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.status = status_reg;
        unique case (state_reg)
            S_IDLE:      cmd.op = accept ? wsts_pkg::OP_CAPTURE : wsts_pkg::OP_NONE;
            S_DECODE:    cmd.op = wsts_pkg::OP_NONE;
            S_OWN_RD:    cmd.op = wsts_pkg::OP_OWN_READ;
            S_DELTA:     cmd.op = wsts_pkg::OP_DELTA;
            S_CLIMB:     cmd.op = wsts_pkg::OP_CLIMB;
            S_MULT:      cmd.op = wsts_pkg::OP_MULT;
            S_SCALE:     cmd.op = wsts_pkg::OP_SCALE;
            S_DRAW_RD:   cmd.op = wsts_pkg::OP_DRAW_READ;
            S_DRAW_EVAL: cmd.op = wsts_pkg::OP_DRAW_EVAL;
            S_FINISH:    cmd.op = out_free ? wsts_pkg::OP_LOAD : wsts_pkg::OP_NONE;
            default:     cmd.op = wsts_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            status_reg   <= wsts_pkg::ST_OK;
        end else begin
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    priority if (stat.is_write) begin
                        if (stat.write_bad) begin
                            status_reg <= wsts_pkg::ST_RANGE;
                            state_reg  <= S_FINISH;
                        end else begin
                            status_reg <= wsts_pkg::ST_OK;
                            state_reg  <= S_OWN_RD;
                        end
                    end else if (stat.is_draw) begin
                        if (stat.draw_empty) begin
                            status_reg <= wsts_pkg::ST_EMPTY;
                            state_reg  <= S_FINISH;
                        end else begin
                            status_reg <= wsts_pkg::ST_OK;
                            state_reg  <= S_MULT;
                        end
                    end else begin
                        status_reg <= wsts_pkg::ST_OK;
                        state_reg  <= S_FINISH;
                    end
                end
                S_OWN_RD:  state_reg <= S_DELTA;
                S_DELTA:   state_reg <= S_CLIMB;
                S_CLIMB: begin
                    if (stat.at_root) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_MULT:    state_reg <= S_SCALE;
                S_SCALE:   state_reg <= S_DRAW_RD;
                S_DRAW_RD: state_reg <= S_DRAW_EVAL;
                S_DRAW_EVAL: begin
                    state_reg <= stat.pick_done ? S_FINISH : S_DRAW_RD;
                end
                S_FINISH: begin
                    if (out_free) begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/wsts_dp.sv]
// Datapath of the weighted sum tree sampler: weight and subtree memories,
// draw scaling, descent and climb arithmetic, and the result register. Depends on wsts_pkg.
`default_nettype none

module wsts_dp #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire wsts_pkg::ctrl_cmd_t             cmd,
    output wsts_pkg::dp_stat_t                   stat,
    input  wire logic [wsts_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [wsts_pkg::MODE_W-1:0]     s_tuser,
    output logic [wsts_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser
);

    localparam int IDX_W  = wsts_pkg::IDX_W;
    localparam int W_W    = wsts_pkg::W_W;
    localparam int SUM_W  = wsts_pkg::SUM_W;
    localparam int FULL   = 2 ** IDX_W;
    localparam int DEPTH  = (MAX_NODES < FULL) ? MAX_NODES : FULL;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int XW     = IDX_W + 2;
    localparam int EW     = SUM_W + 2;
    localparam int PAD_W  = wsts_pkg::M_TDATA_W - IDX_W - 2 * SUM_W;

    logic [2*W_W-1:0]   own_mem [DEPTH];
    logic [2*SUM_W-1:0] sub_mem [DEPTH];

    logic [wsts_pkg::MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [W_W-1:0]     sw_reg;
    logic [W_W-1:0]     tw_reg;
    logic [W_W-1:0]     dp_reg;
    logic [CW-1:0]      count_reg;
    logic [SUM_W-1:0]   root_s_reg;
    logic [SUM_W-1:0]   root_t_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [SUM_W-1:0]   r_reg;
    logic [SUM_W-1:0]   prod_hi_reg;
    logic [W_W-1:0]     prod_lo_reg;
    logic [SUM_W-1:0]   delta_s_reg;
    logic [SUM_W-1:0]   delta_t_reg;
    logic [2*W_W-1:0]   own_q_reg;
    logic [2*SUM_W-1:0] sub_q_reg;
    logic               own_ok_reg;
    logic               sub_ok_reg;
    logic               left_ok_reg;
    logic               right_ok_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic [IDX_W-1:0]   out_picked_reg;
    wsts_pkg::status_t  out_status_reg;
    logic [SUM_W-1:0]   out_src_reg;
    logic [SUM_W-1:0]   out_tgt_reg;

    logic [IDX_W:0]     idx_ext;
    logic [IDX_W:0]     cnt_ext;
    logic               idx_lt_cnt;
    logic               idx_eq_cnt;
    logic               use_src;
    logic               is_draw;
    logic [SUM_W-1:0]   root_sel;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      cnt_x;
    logic [IDX_W-1:0]   parent;
    logic [W_W-1:0]     own_old_s;
    logic [W_W-1:0]     own_old_t;
    logic [SUM_W-1:0]   sub_new_s;
    logic [SUM_W-1:0]   sub_new_t;
    logic [W_W-1:0]     own_w;
    logic [SUM_W-1:0]   sub_w;
    logic [EW-1:0]      e1;
    logic [EW-1:0]      e2;
    logic               lt_left;
    logic               pick_done;
    logic [SUM_W-1:0]   mul_hi;
    logic [2*W_W-1:0]   mul_lo;
    logic [AW-1:0]      own_rd_addr;
    logic [AW-1:0]      sub_rd_addr;

    assign idx_ext    = {1'b0, idx_reg};
    assign cnt_ext    = (IDX_W + 1)'(count_reg);
    assign idx_lt_cnt = idx_ext < cnt_ext;
    assign idx_eq_cnt = idx_ext == cnt_ext;
    assign use_src    = mode_reg == wsts_pkg::MODE_DRAW_SRC;
    assign is_draw    = use_src || (mode_reg == wsts_pkg::MODE_DRAW_TGT);
    assign root_sel   = use_src ? root_s_reg : root_t_reg;

    assign left_x  = {1'b0, i_reg, 1'b1};
    assign right_x = left_x + XW'(1);
    assign cnt_x   = XW'(count_reg);
    assign parent  = (i_reg - IDX_W'(1)) >> 1;

    assign own_old_s = own_ok_reg ? own_q_reg[W_W-1:0] : '0;
    assign own_old_t = own_ok_reg ? own_q_reg[2*W_W-1:W_W] : '0;
    assign sub_new_s = (sub_ok_reg ? sub_q_reg[SUM_W-1:0] : '0) + delta_s_reg;
    assign sub_new_t = (sub_ok_reg ? sub_q_reg[2*SUM_W-1:SUM_W] : '0) + delta_t_reg;

    assign own_w     = use_src ? own_q_reg[W_W-1:0] : own_q_reg[2*W_W-1:W_W];
    assign sub_w     = use_src ? sub_q_reg[SUM_W-1:0] : sub_q_reg[2*SUM_W-1:SUM_W];
    assign e1        = EW'(r_reg) - EW'(own_w);
    assign e2        = e1 - EW'(sub_w);
    assign lt_left   = e2[EW-1];
    assign pick_done = e1[EW-1] || !left_ok_reg || (!lt_left && !right_ok_reg);

    assign mul_hi = SUM_W'(dp_reg) * SUM_W'(root_sel[SUM_W-1:W_W]);
    assign mul_lo = (2 * W_W)'(dp_reg) * (2 * W_W)'(root_sel[W_W-1:0]);

    assign own_rd_addr = (cmd.op == wsts_pkg::OP_OWN_READ) ? idx_reg[AW-1:0] : i_reg[AW-1:0];

    always_comb begin
        unique case (cmd.op)
            wsts_pkg::OP_DELTA: sub_rd_addr = idx_reg[AW-1:0];
            wsts_pkg::OP_CLIMB: sub_rd_addr = parent[AW-1:0];
            default:            sub_rd_addr = left_x[AW-1:0];
        endcase
    end

    assign stat.is_write   = mode_reg == wsts_pkg::MODE_WRITE;
    assign stat.is_draw    = is_draw;
    assign stat.write_bad  = (idx_ext > cnt_ext) || (idx_ext >= (IDX_W + 1)'(DEPTH));
    assign stat.draw_empty = (count_reg == '0) || (root_sel == '0);
    assign stat.pick_done  = pick_done;
    assign stat.at_root    = i_reg == '0;

    always_ff @(posedge aclk) begin
        own_q_reg <= own_mem[own_rd_addr];
        sub_q_reg <= sub_mem[sub_rd_addr];
        if (cmd.op == wsts_pkg::OP_DELTA) begin
            own_mem[idx_reg[AW-1:0]] <= {tw_reg, sw_reg};
        end
        if (cmd.op == wsts_pkg::OP_CLIMB) begin
            sub_mem[i_reg[AW-1:0]] <= {sub_new_t, sub_new_s};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            root_s_reg <= '0;
            root_t_reg <= '0;
        end else if (cmd.op == wsts_pkg::OP_CLIMB && i_reg == '0) begin
            root_s_reg <= sub_new_s;
            root_t_reg <= sub_new_t;
            if (idx_eq_cnt) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            wsts_pkg::OP_CAPTURE: begin
                mode_reg <= s_tuser;
                idx_reg  <= s_tdata[IDX_W-1:0];
                sw_reg   <= s_tdata[IDX_W +: W_W];
                tw_reg   <= s_tdata[IDX_W + W_W +: W_W];
                dp_reg   <= s_tdata[IDX_W + 2 * W_W +: W_W];
            end
            wsts_pkg::OP_OWN_READ: begin
                own_ok_reg <= idx_lt_cnt;
            end
            wsts_pkg::OP_DELTA: begin
                delta_s_reg <= SUM_W'(sw_reg) - SUM_W'(own_old_s);
                delta_t_reg <= SUM_W'(tw_reg) - SUM_W'(own_old_t);
                sub_ok_reg  <= idx_lt_cnt;
                i_reg       <= idx_reg;
            end
            wsts_pkg::OP_CLIMB: begin
                sub_ok_reg <= 1'b1;
                i_reg      <= parent;
            end
            wsts_pkg::OP_MULT: begin
                prod_hi_reg <= mul_hi;
                prod_lo_reg <= mul_lo[2*W_W-1:W_W];
            end
            wsts_pkg::OP_SCALE: begin
                r_reg <= prod_hi_reg + SUM_W'(prod_lo_reg);
                i_reg <= '0;
            end
            wsts_pkg::OP_DRAW_READ: begin
                left_ok_reg  <= left_x < cnt_x;
                right_ok_reg <= right_x < cnt_x;
            end
            wsts_pkg::OP_DRAW_EVAL: begin
                if (pick_done) begin
                    pick_reg <= i_reg;
                end else if (lt_left) begin
                    i_reg <= left_x[IDX_W-1:0];
                    r_reg <= e1[SUM_W-1:0];
                end else begin
                    i_reg <= right_x[IDX_W-1:0];
                    r_reg <= e2[SUM_W-1:0];
                end
            end
            wsts_pkg::OP_LOAD: begin
                priority if (stat.is_write) begin
                    out_picked_reg <= idx_reg;
                end else if (is_draw && cmd.status == wsts_pkg::ST_OK) begin
                    out_picked_reg <= pick_reg;
                end else begin
                    out_picked_reg <= '0;
                end
                out_status_reg <= cmd.status;
                out_src_reg    <= root_s_reg;
                out_tgt_reg    <= root_t_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = {{PAD_W{1'b0}}, out_tgt_reg, out_src_reg, out_picked_reg};
    assign m_tuser = out_status_reg;

endmodule

`default_nettype wire

[src/weighted_sum_tree_sampler.sv]
// Weighted sum tree sampler: a heap-ordered binary tree of up to MAX_NODES nodes (at most
// 1024 addressable) holding a source and a target weight per node with subtree totals. A write
// sets or appends a node and climbs to the root, one tree level per cycle. A draw scales
// draw_point by the root total, then descends from the root, visiting the node, then its left
// subtree, then its right; every level takes a memory read state and then a compare state.
// Rejected writes, empty draws and the unused mode skip the tree walk. One item is in work at
// a time; a finished result waits in the output register while the next item is taken.
// Unwritten memory reads as zero through the node count, so no clearing pass is needed.
// Depends on wsts_pkg, wsts_ctrl and wsts_dp.
`default_nettype none

module weighted_sum_tree_sampler #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // node_index[9:0], source_weight[41:10], target_weight[73:42], draw_point[105:74]
    input  wire logic [wsts_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [wsts_pkg::MODE_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // picked_index[9:0], source_sum[51:10], target_sum[93:52]
    output logic [wsts_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [1:0]                           m_tuser
);

    wsts_pkg::ctrl_cmd_t cmd;
    wsts_pkg::dp_stat_t  stat;

    wsts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsts_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef SYNTH
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input was accepted while an item was still in work.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == wsts_pkg::OP_LOAD |-> !m_tvalid || m_tready)
        else $error("A result was loaded over one not yet transferred.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == wsts_pkg::ST_OK || m_tuser == wsts_pkg::ST_EMPTY
                     || m_tuser == wsts_pkg::ST_RANGE)
        else $error("Result carries an undefined status code.");
`endif

endmodule

`default_nettype wire
